>>> design/assert_macros.svh
// Shared assertion forms, clocked on clock and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ctb_pkg.sv
`default_nettype none

package ctb_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int RADIX = 16;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_DELETE   = 3'd1,
      CMD_FORWARD  = 3'd2,
      CMD_BACKWARD = 3'd3,
      CMD_START    = 3'd4,
      CMD_END      = 3'd5,
      CMD_READ     = 3'd6
   } ctb_cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } ctb_status_type;

   typedef struct packed {
      ctb_cmd_type command;
      logic [7:0]  char_in;
      logic [7:0]  read_index;
   } ctb_req_type;

   typedef struct packed {
      ctb_status_type status;
      logic [7:0]     char_out;
      logic [8:0]     cursor_pos;
      logic [8:0]     text_length;
   } ctb_rsp_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic       insert_en;
      logic       delete_en;
      logic [7:0] char_in;
      logic [7:0] read_index;
   } ctb_cell_cmd_type;

   // Node count of a read tree level; level 0 is the leaves.
   function automatic int tree_width(input int leaves, input int level);
      int w;
      w = leaves;
      for (int i = 0; i < level; i++) begin
         w = (w + RADIX - 1) / RADIX;
      end
      return w;
   endfunction

   // Registered levels needed to reduce the leaves to one node.
   function automatic int tree_levels(input int leaves);
      int w;
      int lv;
      w = leaves;
      lv = 0;
      for (int i = 0; i < 32; i++) begin
         if (w > 1) begin
            w = (w + RADIX - 1) / RADIX;
            lv++;
         end
      end
      return lv;
   endfunction

endpackage

`default_nettype wire

>>> design/ctb_cell.sv
`default_nettype none

module ctb_cell #(
   parameter int CAPACITY = ctb_pkg::CAPACITY_DEFAULT,
   parameter int INDEX    = 0
) (
   input  logic                           clock,
   input  ctb_pkg::ctb_cell_cmd_type      cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]  cursor,
   input  logic [$clog2(CAPACITY+1)-1:0]  count,
   input  logic [7:0]                     left_data,
   input  logic [7:0]                     right_data,
   output logic [7:0]                     data,
   output logic [7:0]                     leaf
);
   import ctb_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] POS = CW'(INDEX);

   logic [7:0] data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.insert_en) begin
         // open a slot at the cursor: cells past it take the left neighbor
         if (POS > cursor) begin
            data_in = left_data;
         end else if (POS == cursor) begin
            data_in = cmd.char_in;
         end
      end else if (cmd.delete_en) begin
         // close the gap: cells from the cursor on take the right neighbor
         if (POS >= cursor) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   // drive the byte into the read tree only when this cell is addressed and live
   assign leaf = ((32'(cmd.read_index) == INDEX) && (POS < count)) ? data_ff : 8'd0;

endmodule

`default_nettype wire

>>> design/ctb_or_tree.sv
`default_nettype none

module ctb_or_tree #(
   parameter int LEAVES = ctb_pkg::CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic [7:0] leaf [LEAVES],
   output logic [7:0] root
);
   import ctb_pkg::*;

   localparam int LEVELS = tree_levels(LEAVES);
   localparam int SPAN   = RADIX * tree_width(LEAVES, 1);

   logic [7:0] leaf_pad [SPAN];
   logic [7:0] node_ff  [LEVELS][SPAN];
   logic [7:0] node_in  [LEVELS][SPAN];

   for (genvar j = 0; j < SPAN; j++) begin : g_pad
      if (j < LEAVES) begin : g_live
         assign leaf_pad[j] = leaf[j];
      end else begin : g_zero
         assign leaf_pad[j] = 8'd0;
      end
   end

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar j = 0; j < SPAN; j++) begin : g_node
         if (j < tree_width(LEAVES, l + 1)) begin : g_live
            if (l == 0) begin : g_first
               always_comb begin
                  logic [7:0] acc;
                  acc = 8'd0;
                  for (int i = 0; i < RADIX; i++) begin
                     acc = acc | leaf_pad[j*RADIX + i];
                  end
                  node_in[l][j] = acc;
               end
            end else begin : g_upper
               always_comb begin
                  logic [7:0] acc;
                  acc = 8'd0;
                  for (int i = 0; i < RADIX; i++) begin
                     acc = acc | node_ff[l-1][j*RADIX + i];
                  end
                  node_in[l][j] = acc;
               end
            end
         end else begin : g_idle
            assign node_in[l][j] = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign root = node_ff[LEVELS-1][0];

endmodule

`default_nettype wire

>>> design/cursor_text_buffer.sv
`default_nettype none
// Channel   Ports                        Direction  Payload
// request   req_valid/req_ready/req_data  in        command, char_in, read_index
// response  rsp_valid/rsp_ready/rsp_data  out       status, char_out, cursor_pos, text_length
//
// Edit and move commands complete on the accepting edge: an edit shifts the cells
// at and past the cursor on that edge, and the result register loads on that same edge.
// A read latches its index and waits in S_TREE while the registered OR tree, radix 16,
// gathers the addressed cell's byte; S_DONE then loads the result register.
// A new command is taken in S_IDLE while the result register is empty or being drained.
// Synchronous reset clears cursor, length, state and response valid; the text contents are not cleared.
`include "assert_macros.svh"

module cursor_text_buffer #(
   parameter int CAPACITY = ctb_pkg::CAPACITY_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ctb_pkg::ctb_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ctb_pkg::ctb_rsp_type rsp_data
);
   import ctb_pkg::*;

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int LEVELS = tree_levels(CAPACITY);
   localparam int WW     = $clog2(LEVELS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_TREE,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [WW-1:0]    wait_ff, wait_in;
   logic [7:0]       index_ff, index_in;
   ctb_status_type   rd_status_ff, rd_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ctb_rsp_type      rsp_data_ff, rsp_data_in;

   logic             slot_free;
   logic             accept;
   ctb_cell_cmd_type cell_cmd;
   logic [7:0]       cell_data [CAPACITY];
   logic [7:0]       leaf      [CAPACITY];
   logic [7:0]       root;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ctb_status_type status_v;
      status_v     = ST_OK;
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      wait_in      = wait_ff;
      index_in     = index_ff;
      rd_status_in = rd_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cell_cmd.insert_en  = 1'b0;
      cell_cmd.delete_en  = 1'b0;
      cell_cmd.char_in    = req_data.char_in;
      cell_cmd.read_index = index_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  CMD_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_v = ST_FULL;
                     end else begin
                        cell_cmd.insert_en = 1'b1;
                        cursor_in = cursor_ff + 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (cursor_ff < count_ff) begin
                        cell_cmd.delete_en = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_FORWARD: begin
                     if (cursor_ff < count_ff) begin
                        cursor_in = cursor_ff + 1'b1;
                     end
                  end
                  CMD_BACKWARD: begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - 1'b1;
                     end
                  end
                  CMD_START: cursor_in = '0;
                  CMD_END:   cursor_in = count_ff;
                  default: ;
               endcase

               if (req_data.command == CMD_READ) begin
                  // latch the address and wait in S_TREE for the registered tree to settle
                  state_in     = S_TREE;
                  wait_in      = WW'(LEVELS);
                  index_in     = req_data.read_index;
                  rd_status_in = (32'(req_data.read_index) < 32'(count_ff)) ? ST_OK
                                                                          : ST_RANGE;
               end else begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = status_v;
                  rsp_data_in.char_out    = 8'd0;
                  rsp_data_in.cursor_pos  = 9'(cursor_in);
                  rsp_data_in.text_length = 9'(count_in);
               end
            end
         end
         S_TREE: begin
            wait_in = wait_ff - 1'b1;
            if (wait_ff == WW'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = rd_status_ff;
               rsp_data_in.char_out    = root;
               rsp_data_in.cursor_pos  = 9'(cursor_ff);
               rsp_data_in.text_length = 9'(count_ff);
               state_in                = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      index_ff     <= index_in;
      rd_status_ff <= rd_status_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_chain
      logic [7:0] left_w;
      logic [7:0] right_w;
      if (k == 0) begin : g_head
         assign left_w = 8'd0;
      end else begin : g_left
         assign left_w = cell_data[k-1];
      end
      if (k == CAPACITY - 1) begin : g_tail
         assign right_w = 8'd0;
      end else begin : g_right
         assign right_w = cell_data[k+1];
      end

      ctb_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (k)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .cursor     (cursor_ff),
         .count      (count_ff),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[k]),
         .leaf       (leaf[k])
      );
   end

   ctb_or_tree #(
      .LEAVES (CAPACITY)
   ) u_tree (
      .clock (clock),
      .leaf  (leaf),
      .root  (root)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(CAPACITY), "length beyond capacity")
   `ASSERT_ALWAYS(a_cursor_bound, cursor_ff <= count_ff, "cursor past end of text")
   `ASSERT_NEXT(a_insert_grows, accept && req_data.command == CMD_INSERT && count_ff < CW'(CAPACITY), count_ff == $past(count_ff) + 1'b1, "insert did not grow text")
   `ASSERT_NEXT(a_read_holds_rsp, accept && req_data.command == CMD_READ, !rsp_valid_ff, "read result issued before tree settled")

endmodule

`default_nettype wire

>>> dv/cursor_text_buffer_tb.sv
`default_nettype none

module cursor_text_buffer_tb;
   import ctb_pkg::*;

   localparam int TEXT_CAPACITY    = CAPACITY_DEFAULT;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 20;
   localparam int REQ_BITS         = $bits(ctb_req_type);
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ctb_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   ctb_rsp_type rsp_data;

   // Edit-buffer mirror, updated on each accepted transfer
   logic [7:0]  text_mem [TEXT_CAPACITY];
   int          model_cursor;
   int          model_length;
   ctb_rsp_type predicted_rsp_q [$];

   int mismatch_count;
   bit steady_mode;
   bit long_hold_req;

   cursor_text_buffer #(
      .CAPACITY(TEXT_CAPACITY)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   function automatic ctb_rsp_type apply_edit(input ctb_req_type cmd);
      ctb_rsp_type r;
      r.status   = ST_OK;
      r.char_out = 8'h00;
      case (cmd.command)
         CMD_INSERT: begin
            if (model_length >= TEXT_CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (int k = model_length; k > model_cursor; k--) begin
                  text_mem[k] = text_mem[k - 1];
               end
               text_mem[model_cursor] = cmd.char_in;
               model_cursor++;
               model_length++;
            end
         end
         CMD_DELETE: begin
            if (model_cursor < model_length) begin
               for (int k = model_cursor; k + 1 < model_length; k++) begin
                  text_mem[k] = text_mem[k + 1];
               end
               model_length--;
            end
         end
         CMD_FORWARD: begin
            if (model_cursor < model_length) model_cursor++;
         end
         CMD_BACKWARD: begin
            if (model_cursor > 0) model_cursor--;
         end
         CMD_START: model_cursor = 0;
         CMD_END:   model_cursor = model_length;
         CMD_READ: begin
            if (int'(cmd.read_index) < model_length) begin
               r.char_out = text_mem[cmd.read_index];
            end else begin
               r.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      r.cursor_pos  = 9'(model_cursor);
      r.text_length = 9'(model_length);
      return r;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic ctb_req_type make_req(input ctb_cmd_type c, input logic [7:0] ch,
                                            input logic [7:0] idx);
      ctb_req_type q;
      q.command    = c;
      q.char_in    = ch;
      q.read_index = idx;
      return q;
   endfunction

   // Favor indexes inside the text so most reads return data
   function automatic logic [7:0] pick_index();
      if (model_length > 0 && $urandom_range(0, 3) != 0) begin
         return 8'($urandom_range(0, model_length - 1));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_command(input ctb_req_type cmd);
      int gap;
      logic [REQ_BITS-1:0] filler;
      gap = pick_gap();
      if (gap > 0) begin
         filler = REQ_BITS'($urandom);
         req_valid <= 1'b0;
         req_data  <= filler;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted_rsp_q.push_back(apply_edit(cmd));
   endtask

   task automatic send_op(input ctb_cmd_type c, input logic [7:0] ch, input logic [7:0] idx);
      send_command(make_req(c, ch, idx));
   endtask

   task automatic check_field(input string label, input logic [8:0] want,
                              input logic [8:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // Result checker
   initial begin : result_check
      ctb_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (predicted_rsp_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = predicted_rsp_q.pop_front();
               check_field("status", 9'(want.status), 9'(rsp_data.status));
               check_field("char_out", 9'(want.char_out), 9'(rsp_data.char_out));
               check_field("cursor_pos", want.cursor_pos, rsp_data.cursor_pos);
               check_field("text_length", want.text_length, rsp_data.text_length);
            end
         end
      end
   end

   // Result receiver with random stalls and one requested long hold-off
   initial begin : result_sink
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            hold = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            rsp_ready <= (hold == 0);
            if (hold > 0) hold--;
         end
      end
   end

   task automatic test_edge_cases();
      send_op(CMD_DELETE, 8'($urandom), 8'($urandom));
      send_op(CMD_FORWARD, 8'($urandom), 8'($urandom));
      send_op(CMD_BACKWARD, 8'($urandom), 8'($urandom));
      send_op(CMD_READ, 8'($urandom), 8'h00);
      send_op(CMD_READ, 8'($urandom), 8'hFF);
      send_op(ctb_cmd_type'(CMD_UNUSED), 8'($urandom), 8'($urandom));
      send_op(CMD_START, 8'($urandom), 8'($urandom));
      send_op(CMD_END, 8'($urandom), 8'($urandom));
      send_op(CMD_INSERT, 8'h00, 8'($urandom));
      send_op(CMD_INSERT, 8'hFF, 8'($urandom));
      send_op(CMD_INSERT, 8'h41, 8'($urandom));
      send_op(CMD_BACKWARD, 8'($urandom), 8'($urandom));
      send_op(CMD_BACKWARD, 8'($urandom), 8'($urandom));
      // insert in the middle shifts the tail up
      send_op(CMD_INSERT, 8'h5A, 8'($urandom));
      send_op(CMD_READ, 8'($urandom), 8'd0);
      send_op(CMD_READ, 8'($urandom), 8'd1);
      send_op(CMD_READ, 8'($urandom), 8'd2);
      send_op(CMD_READ, 8'($urandom), 8'd3);
      send_op(CMD_READ, 8'($urandom), 8'd4);
      send_op(CMD_DELETE, 8'($urandom), 8'($urandom));
      send_op(CMD_READ, 8'($urandom), 8'd2);
      send_op(CMD_END, 8'($urandom), 8'($urandom));
      send_op(CMD_DELETE, 8'($urandom), 8'($urandom));
      send_op(CMD_FORWARD, 8'($urandom), 8'($urandom));
      send_op(CMD_START, 8'($urandom), 8'($urandom));
      send_op(CMD_BACKWARD, 8'($urandom), 8'($urandom));
   endtask

   task automatic test_full_buffer();
      while (model_length < TEXT_CAPACITY) begin
         if ($urandom_range(0, 4) == 0) begin
            send_op(($urandom_range(0, 1) == 0) ? CMD_BACKWARD : CMD_FORWARD,
                    8'($urandom), 8'($urandom));
         end else begin
            send_op(CMD_INSERT, 8'($urandom), 8'($urandom));
         end
      end
      send_op(CMD_INSERT, 8'hFF, 8'($urandom));
      send_op(CMD_INSERT, 8'h00, 8'($urandom));
      send_op(CMD_READ, 8'($urandom), 8'hFF);
      send_op(CMD_READ, 8'($urandom), 8'h00);
      send_op(CMD_END, 8'($urandom), 8'($urandom));
      send_op(CMD_INSERT, 8'($urandom), 8'($urandom));
      send_op(CMD_DELETE, 8'($urandom), 8'($urandom));
      send_op(CMD_FORWARD, 8'($urandom), 8'($urandom));
      send_op(CMD_START, 8'($urandom), 8'($urandom));
      send_op(CMD_DELETE, 8'($urandom), 8'($urandom));
      send_op(CMD_INSERT, 8'($urandom), 8'($urandom));
      send_op(CMD_INSERT, 8'($urandom), 8'($urandom));
      send_op(CMD_READ, 8'($urandom), 8'hFF);
   endtask

   task automatic run_mix(input int count, input int ins_w, input int del_w);
      int total;
      int r;
      int b;
      ctb_cmd_type c;
      b = ins_w + del_w;
      total = b + 47;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, total - 1);
         if (r < ins_w) c = CMD_INSERT;
         else if (r < b) c = CMD_DELETE;
         else if (r < b + 10) c = CMD_FORWARD;
         else if (r < b + 20) c = CMD_BACKWARD;
         else if (r < b + 23) c = CMD_START;
         else if (r < b + 26) c = CMD_END;
         else if (r < b + 46) c = CMD_READ;
         else c = ctb_cmd_type'(CMD_UNUSED);
         send_op(c, 8'($urandom), pick_index());
      end
   endtask

   task automatic test_backpressure();
      // receiver holds off while the sender keeps offering
      long_hold_req = 1'b1;
      run_mix(40, 30, 10);
   endtask

   task automatic test_random_edits();
      steady_mode = 1'b1;
      run_mix(150, 20, 20);
      steady_mode = 1'b0;
      run_mix(300, 60, 5);
      run_mix(250, 20, 20);
      run_mix(250, 5, 50);
      run_mix(250, 60, 5);
      run_mix(150, 20, 20);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      mismatch_count = 0;
      steady_mode    = 1'b0;
      long_hold_req  = 1'b0;
      model_cursor   = 0;
      model_length   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_full_buffer();
      test_backpressure();
      test_random_edits();

      req_valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
